[rtl/pip_pkg.sv]
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Shared widths, request and result codes, controller states and the record
// that travels from cell to cell along the edge chain.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int IndexWidth      = 8;
  localparam int CountWidth      = 9;
  localparam int CoordFieldWidth = 16;
  localparam int InDataWidth     = 40;
  localparam int OutDataWidth    = 8;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    LOC_EXTERIOR = 2'd0,
    LOC_ON_EDGE  = 2'd1,
    LOC_INTERIOR = 2'd2
  } loc_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // Query token and the running result that rides along with it.
  typedef struct packed {
    logic tok;
    logic parity;
    logic on_edge;
  } acc_t;

endpackage

[rtl/pip_cell.sv]
// ----------------------------------------------------------------------------
// Point-in-polygon edge cell
// Holds one vertex and tests the edge from it to the next vertex in use.
// The cross product against the held query point is formed every cycle; when
// the token passes, the cell updates the crossing parity and on-edge flag.
// ----------------------------------------------------------------------------
module pip_cell #(
  parameter int INDEX        = 0,
  parameter int MAX_VERTICES = 256,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    wr_valid,
  input  logic [pip_pkg::IndexWidth-1:0]          wr_index,
  input  logic signed [COORD_WIDTH-1:0]           wr_x,
  input  logic signed [COORD_WIDTH-1:0]           wr_y,
  input  logic [pip_pkg::CountWidth-1:0]          count,
  input  logic signed [COORD_WIDTH-1:0]           point_x,
  input  logic signed [COORD_WIDTH-1:0]           point_y,
  input  logic signed [COORD_WIDTH-1:0]           next_x,
  input  logic signed [COORD_WIDTH-1:0]           next_y,
  input  logic signed [COORD_WIDTH-1:0]           first_x,
  input  logic signed [COORD_WIDTH-1:0]           first_y,
  output logic signed [COORD_WIDTH-1:0]           vtx_x,
  output logic signed [COORD_WIDTH-1:0]           vtx_y,
  input  pip_pkg::acc_t                           chain_in,
  output pip_pkg::acc_t                           chain_out
);
  import pip_pkg::*;

  localparam int   DW      = COORD_WIDTH + 1;
  localparam int   PW      = 2 * COORD_WIDTH + 2;
  localparam int   CW      = PW + 1;
  localparam logic HasNext = (INDEX + 1 < MAX_VERTICES);

  logic                 use_next;
  logic                 active;
  logic signed [COORD_WIDTH-1:0] bx, by;
  logic signed [DW-1:0] dx_ab, dy_ab, dx_pa, dy_pa;
  logic signed [PW-1:0] prod_l, prod_r;
  logic                 box, straddle, rising;
  logic signed [CW-1:0] cr;
  logic                 cr_zero, cr_pos, cr_neg;
  logic                 hit, crossing;

  always_ff @(posedge clk) begin
    if (wr_valid && (32'(wr_index) == 32'(INDEX))) begin
      vtx_x <= wr_x;
      vtx_y <= wr_y;
    end
  end

  // The closing edge of the polygon wraps back to vertex zero.
  assign use_next = HasNext && (32'(count) > 32'(INDEX + 1));
  assign active   = 32'(count) > 32'(INDEX);
  assign bx       = use_next ? next_x : first_x;
  assign by       = use_next ? next_y : first_y;

  assign dx_ab = DW'(bx) - DW'(vtx_x);
  assign dy_ab = DW'(by) - DW'(vtx_y);
  assign dx_pa = DW'(point_x) - DW'(vtx_x);
  assign dy_pa = DW'(point_y) - DW'(vtx_y);

  // Geometry against the held point; settled before the token arrives.
  always_ff @(posedge clk) begin
    prod_l   <= PW'(dx_ab) * PW'(dy_pa);
    prod_r   <= PW'(dy_ab) * PW'(dx_pa);
    box      <= ((point_x >= vtx_x && point_x <= bx) || (point_x >= bx && point_x <= vtx_x)) &&
                ((point_y >= vtx_y && point_y <= by) || (point_y >= by && point_y <= vtx_y));
    straddle <= (vtx_x <= point_x) != (bx <= point_x);
    rising   <= vtx_x < bx;
  end

  assign cr      = CW'(prod_l) - CW'(prod_r);
  assign cr_zero = (cr == '0);
  assign cr_neg  = cr[CW-1];
  assign cr_pos  = !cr_neg && !cr_zero;

  assign hit      = active && cr_zero && box;
  assign crossing = active && straddle && (rising ? cr_pos : cr_neg);

  always_ff @(posedge clk) begin
    chain_out.parity  <= chain_in.parity ^ crossing;
    chain_out.on_edge <= chain_in.on_edge | hit;
    if (rst) begin
      chain_out.tok <= 1'b0;
    end else begin
      chain_out.tok <= chain_in.tok;
    end
  end

endmodule

[rtl/point_in_polygon_test.sv]
// A query is not accepted while the token of the one before walks the chain of
// edge cells one cell per cycle; vertex loads are accepted back to back while
// the controller is idle and the result buffer has a free slot.
// Reset: controller, token chain and result buffer clear and vertex_count
// returns to 3; stored vertices are undefined until loaded.
// ----------------------------------------------------------------------------
// Point-in-polygon test
// Even-odd ray casting over a row of edge cells. Load transfers write a
// vertex into its cell; a query launches a token that visits every cell and
// collects crossings below the point and exact on-edge hits.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // coord_y[39:24], coord_x[23:8], vertex_index[7:0]
  input  logic [pip_pkg::InDataWidth-1:0]       s_tdata,
  // req_type[0]
  input  logic [0:0]                            s_tuser,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // zero fill[7:2], location[1:0]
  output logic [pip_pkg::OutDataWidth-1:0]      m_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  input  logic [pip_pkg::CountWidth-1:0]        cfg_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready
);
  import pip_pkg::*;

  state_t state, state_next;
  logic [CountWidth-1:0] vertex_count;
  logic in_xfer, query_start, load_start;
  logic [1:0] launch;
  logic signed [COORD_WIDTH-1:0] in_x, in_y, point_x, point_y;
  logic signed [COORD_WIDTH-1:0] vx [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] vy [MAX_VERTICES];
  acc_t chain [MAX_VERTICES+1];
  logic [MAX_VERTICES-1:0] tok_vec;
  logic chain_done;
  loc_t result;
  loc_t slot0, slot1, slot0_next, slot1_next;
  logic [1:0] fifo_count, fifo_count_next;
  logic push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CountWidth'(3);
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  assign in_xfer     = s_tvalid && s_tready;
  assign query_start = in_xfer && (s_tuser[0] == REQ_QUERY);
  assign load_start  = in_xfer && (s_tuser[0] == REQ_LOAD);

  // Fields wider than the coordinate are truncated; narrower ones zero-fill.
  assign in_x = COORD_WIDTH'(s_tdata[IndexWidth +: CoordFieldWidth]);
  assign in_y = COORD_WIDTH'(s_tdata[IndexWidth + CoordFieldWidth +: CoordFieldWidth]);

  always_ff @(posedge clk) begin
    if (query_start) begin
      point_x <= in_x;
      point_y <= in_y;
    end
  end

  // The token launch is registered so that it meets cell products that reflect the new point.
  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 2'b00;
    end else begin
      launch <= {launch[0], query_start};
    end
  end

  assign chain[0] = '{tok: launch[1], parity: 1'b0, on_edge: 1'b0};

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    pip_cell #(
      .INDEX       (i),
      .MAX_VERTICES(MAX_VERTICES),
      .COORD_WIDTH (COORD_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_valid (load_start),
      .wr_index (s_tdata[IndexWidth-1:0]),
      .wr_x     (in_x),
      .wr_y     (in_y),
      .count    (vertex_count),
      .point_x  (point_x),
      .point_y  (point_y),
      .next_x   (vx[(i + 1) % MAX_VERTICES]),
      .next_y   (vy[(i + 1) % MAX_VERTICES]),
      .first_x  (vx[0]),
      .first_y  (vy[0]),
      .vtx_x    (vx[i]),
      .vtx_y    (vy[i]),
      .chain_in (chain[i]),
      .chain_out(chain[i+1])
    );
    assign tok_vec[i] = chain[i+1].tok;
  end

  assign chain_done = chain[MAX_VERTICES].tok;

  always_comb begin
    if (chain[MAX_VERTICES].on_edge) begin
      result = LOC_ON_EDGE;
    end else if (chain[MAX_VERTICES].parity) begin
      result = LOC_INTERIOR;
    end else begin
      result = LOC_EXTERIOR;
    end
  end

  // Controller.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (query_start) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (chain_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: s_tready = (fifo_count != 2'd2);
      ST_RUN:  s_tready = 1'b0;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Two-entry result buffer; a query is only launched while a slot is free.
  assign push     = chain_done;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (fifo_count != 2'd0);
  assign m_tdata  = {{(OutDataWidth-2){1'b0}}, slot0};

  always_comb begin
    slot0_next      = slot0;
    slot1_next      = slot1;
    fifo_count_next = fifo_count;
    case ({push, pop})
      2'b10: begin
        if (fifo_count == 2'd0) slot0_next = result;
        else                    slot1_next = result;
        fifo_count_next = fifo_count + 2'd1;
      end
      2'b01: begin
        slot0_next      = slot1;
        fifo_count_next = fifo_count - 2'd1;
      end
      2'b11: begin
        if (fifo_count == 2'd1) begin
          slot0_next = result;
        end else begin
          slot0_next = slot1;
          slot1_next = result;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_count <= 2'd0;
    end else begin
      fifo_count <= fifo_count_next;
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vec))
    else $error("more than one query token in the cell chain");

  a_query_runs: assert property (@(posedge clk) disable iff (rst)
    query_start |=> (state == ST_RUN))
    else $error("query transfer did not start a walk");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    chain_done |-> (state == ST_RUN))
    else $error("token left the chain while no query was running");

  a_buffer_room: assert property (@(posedge clk) disable iff (rst)
    chain_done |-> (fifo_count != 2'd2))
    else $error("result buffer overflow");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon test bench
// Loads polygons through the request stream, queries points against them and
// checks every answered location against a bit-exact classifier kept in the
// bench. The vertex count is rewritten between phases, from zero up to the
// largest value the register holds, while both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import pip_pkg::*;

  localparam int MaxVerts    = 256;
  localparam int TargetItems = 1800;
  localparam int DrainCycles = MaxVerts + 8;
  localparam int MaxReports  = 200;

  typedef struct packed {
    logic                  req;
    logic [IndexWidth-1:0] slot;
    logic signed [15:0]    x;
    logic signed [15:0]    y;
  } pip_item_t;

  logic                    clk;
  logic                    rst       = 1'b1;
  logic [InDataWidth-1:0]  s_tdata   = '0;
  logic [0:0]              s_tuser   = '0;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [OutDataWidth-1:0] m_tdata;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [CountWidth-1:0]   cfg_data  = '0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;

  point_in_polygon_test #(
    .MAX_VERTICES(MaxVerts),
    .COORD_WIDTH (16)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_data (cfg_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Shadow copy of the polygon and the count, updated at each transfer.
  logic signed [15:0]    poly_x [MaxVerts];
  logic signed [15:0]    poly_y [MaxVerts];
  logic [CountWidth-1:0] poly_count = 9'd3;
  loc_t                  expected_locs[$];

  pip_item_t pending_reqs[$];
  int        src_gap    = 0;
  bit        src_burst  = 1'b0;
  int        sink_stall = 0;
  bit        sink_burst = 1'b0;
  int        errors     = 0;
  int        loads_done = 0;
  int        queries_done = 0;
  int        cfg_writes = 0;
  int        items_issued = 0;
  int        loc_seen[3] = '{0, 0, 0};

  // Exact even-odd classification with a vertical ray cast downward.
  function automatic loc_t classify_point(longint px, longint py);
    int          n;
    int          i;
    int          j;
    int unsigned crossings;
    longint      ax, ay, bx, by, cr;
    n = (poly_count > MaxVerts) ? MaxVerts : int'(poly_count);
    crossings = 0;
    for (i = 0; i < n; i++) begin
      j  = (i + 1 < n) ? i + 1 : 0;
      ax = longint'(poly_x[i]);
      ay = longint'(poly_y[i]);
      bx = longint'(poly_x[j]);
      by = longint'(poly_y[j]);
      cr = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
      if (cr == 0 &&
          px >= ((ax < bx) ? ax : bx) && px <= ((ax > bx) ? ax : bx) &&
          py >= ((ay < by) ? ay : by) && py <= ((ay > by) ? ay : by))
        return LOC_ON_EDGE;
      // Half-open test so that a vertex on the ray line counts only once.
      if ((ax <= px) != (bx <= px)) begin
        if ((ax < bx) ? (cr > 0) : (cr < 0))
          crossings++;
      end
    end
    return crossings[0] ? LOC_INTERIOR : LOC_EXTERIOR;
  endfunction

  function automatic void take_request(logic req, logic [InDataWidth-1:0] word);
    logic [IndexWidth-1:0] slot;
    logic signed [15:0]    x;
    logic signed [15:0]    y;
    slot = word[7:0];
    x    = word[23:8];
    y    = word[39:24];
    if (req == REQ_LOAD) begin
      poly_x[slot] = x;
      poly_y[slot] = y;
      loads_done++;
    end else begin
      expected_locs.push_back(classify_point(longint'(x), longint'(y)));
      queries_done++;
    end
  endfunction

  // Request driver: the gap drawn with an item is served after its transfer.
  always @(posedge clk) begin : drive_requests
    pip_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap  <= 0;
    end else begin
      if (s_tvalid && s_tready)
        take_request(s_tuser[0], s_tdata);
      if (s_tvalid && !s_tready) begin
        // Hold the current item until its transfer.
      end else if (src_gap > 0) begin
        src_gap  <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        s_tdata  <= {nxt.y, nxt.x, nxt.slot};
        s_tuser  <= nxt.req;
        s_tvalid <= 1'b1;
        src_gap  <= src_burst ? 0 : $urandom_range(0, 17);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor: each result is held off for a drawn number of cycles.
  always @(posedge clk) begin : check_results
    int   nstall;
    loc_t want;
    if (rst) begin
      m_tready   <= 1'b0;
      sink_stall <= 0;
    end else begin
      nstall = sink_stall;
      if (m_tvalid && m_tready) begin
        if (expected_locs.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: location %0d arrived with no query outstanding", $time, m_tdata);
        end else begin
          want = expected_locs.pop_front();
          if (m_tdata !== OutDataWidth'(want)) begin
            errors++;
            if (errors <= MaxReports)
              $display("%0t: location mismatch, expected %0d, actual %0d",
                       $time, want, m_tdata);
          end else begin
            loc_seen[want]++;
          end
        end
        nstall = sink_burst ? 0 : $urandom_range(0, 17);
      end else if (m_tvalid && sink_stall > 0) begin
        nstall = sink_stall - 1;
      end
      sink_stall <= nstall;
      m_tready   <= (nstall == 0);
    end
  end

  function automatic void queue_item(logic req, int slot, int x, int y);
    pip_item_t item;
    item.req  = req;
    item.slot = slot[IndexWidth-1:0];
    item.x    = x[15:0];
    item.y    = y[15:0];
    pending_reqs.push_back(item);
    items_issued++;
  endfunction

  // Uniform in [-span-1, span]; span 32767 covers the whole coordinate range.
  function automatic int rand_coord(int span);
    return int'($urandom_range(0, 2 * span + 1)) - span - 1;
  endfunction

  function automatic bit bench_busy();
    return pending_reqs.size() != 0 || s_tvalid || expected_locs.size() != 0;
  endfunction

  // Loads give no result, so the block gets a full query latency to finish.
  task automatic settle();
    do begin
      while (bench_busy()) @(posedge clk);
      repeat (DrainCycles) @(posedge clk);
    end while (bench_busy());
  endtask

  task automatic set_count(input int value);
    settle();
    cfg_data  <= value[CountWidth-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    poly_count = value[CountWidth-1:0];
    cfg_writes++;
  endtask

  task automatic run_phase(input int count);
    logic signed [15:0] vx [MaxVerts];
    logic signed [15:0] vy [MaxVerts];
    int eff, span, nq, q, k, e, e2, g, h, t, dx, dy, px, py;
    eff = (count > MaxVerts) ? MaxVerts : count;
    set_count(count);
    src_burst  = ($urandom_range(0, 3) == 0);
    sink_burst = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 3))
      0:       span = 4;
      1:       span = 16;
      2:       span = 300;
      default: span = 32767;
    endcase
    for (k = 0; k < eff; k++) begin
      vx[k] = 16'(rand_coord(span));
      vy[k] = 16'(rand_coord(span));
    end
    // Axis-aligned rectangles give horizontal edges and vertical ray hits.
    if (eff == 4 && $urandom_range(0, 1) == 1) begin
      vx[1] = vx[2];
      vy[1] = vy[0];
      vx[3] = vx[0];
      vy[3] = vy[2];
    end
    for (k = 0; k < eff; k++)
      queue_item(REQ_LOAD, k, int'(vx[k]), int'(vy[k]));

    nq = (eff == 0) ? 5 : $urandom_range(15, 35);
    for (q = 0; q < nq; q++) begin
      e  = (eff == 0) ? 0 : $urandom_range(0, eff - 1);
      e2 = (e + 1 < eff) ? e + 1 : 0;
      px = rand_coord((span < 32000) ? span + 2 : span);
      py = rand_coord((span < 32000) ? span + 2 : span);
      if (eff > 0) begin
        case ($urandom_range(0, 9))
          3: begin
            px = int'(vx[e]);
            py = int'(vy[e]);
          end
          4: px = int'(vx[e]);
          9: py = int'(vy[e]);
          5, 6: begin
            // A lattice point on the edge, found through the gcd of its steps.
            dx = int'(vx[e2]) - int'(vx[e]);
            dy = int'(vy[e2]) - int'(vy[e]);
            g  = (dx < 0) ? -dx : dx;
            h  = (dy < 0) ? -dy : dy;
            while (h != 0) begin
              t = g % h;
              g = h;
              h = t;
            end
            k  = (g == 0) ? 0 : $urandom_range(0, g);
            px = int'(vx[e]) + ((g == 0) ? 0 : k * (dx / g));
            py = int'(vy[e]) + ((g == 0) ? 0 : k * (dy / g));
          end
          7: begin
            px = rand_coord(32767);
            py = rand_coord(32767);
          end
          8: begin
            // Noise: a load into an unused slot or a change of a live vertex.
            if (eff < MaxVerts && $urandom_range(0, 1) == 1) begin
              queue_item(REQ_LOAD, $urandom_range(eff, MaxVerts - 1),
                         rand_coord(32767), rand_coord(32767));
            end else begin
              vx[e] = 16'(rand_coord(span));
              vy[e] = 16'(rand_coord(span));
              queue_item(REQ_LOAD, e, int'(vx[e]), int'(vy[e]));
            end
          end
          default: ;
        endcase
      end
      queue_item(REQ_QUERY, $urandom_range(0, MaxVerts - 1), px, py);
    end
  endtask

  initial begin : stimulus
    int phase;
    int count;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Triangle at the corners of the coordinate range, at the reset count.
    queue_item(REQ_LOAD, 0, -32768, -32768);
    queue_item(REQ_LOAD, 1, 32767, -32768);
    queue_item(REQ_LOAD, 2, -32768, 32767);
    queue_item(REQ_LOAD, 255, 32767, 32767);
    queue_item(REQ_QUERY, 0, -32768, -32768);
    queue_item(REQ_QUERY, 255, 0, 0);
    queue_item(REQ_QUERY, 0, -1, 0);
    queue_item(REQ_QUERY, 0, -100, -100);
    queue_item(REQ_QUERY, 0, 32767, 32767);
    queue_item(REQ_QUERY, 0, -32768, 0);
    queue_item(REQ_QUERY, 0, 100, -32768);
    queue_item(REQ_QUERY, 0, 0, -32767);

    // Diamond: rays that run exactly through vertices.
    set_count(4);
    queue_item(REQ_LOAD, 0, 0, -4);
    queue_item(REQ_LOAD, 1, 4, 0);
    queue_item(REQ_LOAD, 2, 0, 4);
    queue_item(REQ_LOAD, 3, -4, 0);
    queue_item(REQ_QUERY, 0, 0, 0);
    queue_item(REQ_QUERY, 0, 0, 8);
    queue_item(REQ_QUERY, 0, 0, -8);
    queue_item(REQ_QUERY, 0, 0, 4);
    queue_item(REQ_QUERY, 0, 2, 2);
    queue_item(REQ_QUERY, 0, 4, 1);
    queue_item(REQ_QUERY, 0, -4, 0);

    // Empty and degenerate polygons and counts past the store size come first.
    phase = 0;
    while (items_issued < TargetItems) begin
      case (phase)
        0: count = 0;
        1: count = 1;
        2: count = 2;
        3: count = 256;
        4: count = 511;
        5: count = 3;
        default: begin
          case ($urandom_range(0, 19))
            0, 1:    count = $urandom_range(0, 2);
            2, 3:    count = $urandom_range(13, 64);
            4:       count = $urandom_range(200, 256);
            5:       count = $urandom_range(257, 511);
            default: count = $urandom_range(3, 12);
          endcase
        end
      endcase
      run_phase(count);
      phase++;
    end

    settle();
    $display("Ran %0d vertex loads and %0d point queries over %0d vertex count settings.",
             loads_done, queries_done, cfg_writes);
    $display("Matched answers: %0d exterior, %0d on an edge, %0d interior.",
             loc_seen[LOC_EXTERIOR], loc_seen[LOC_ON_EDGE], loc_seen[LOC_INTERIOR]);
    if (errors == 0) begin
      $display("[point_in_polygon_test] OK");
    end else begin
      $display("[point_in_polygon_test] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("%0t: run did not finish, %0d results still outstanding",
             $time, expected_locs.size());
    $display("[point_in_polygon_test] ERROR");
    $finish;
  end

endmodule
